// ----- rtl/smmst_pkg.sv -----
package smmst_pkg;

    localparam int SET_DEPTH_DEF = 16;
    localparam int SITES_DEF     = 2;
    localparam int NQ            = 3;

    localparam int FUNC_W     = 2;
    localparam int SITE_IN_W  = 2;
    localparam int TIME_W     = 32;
    localparam int VAL_W      = 24;
    localparam int BAT_W      = 16;
    localparam int SF_W       = 8;
    localparam int SUM_W      = 48;
    localparam int CNT_W      = 24;
    localparam int QTY_W      = 3;
    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 192;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 24'sh7FFFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 24'sh800000;
    localparam logic signed [SUM_W-1:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 48'sh8000_0000_0000;
    localparam logic [CNT_W-1:0]        CNT_MAX = '1;
    localparam logic [1:0]              LAST_Q  = 2'd2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_RECORD = 2'd0,
        FUNC_REPORT = 2'd1,
        FUNC_CLEAR  = 2'd2
    } func_t;

    typedef enum logic [QTY_W-1:0] {
        QTY_TEMP   = 3'd0,
        QTY_HUM    = 3'd1,
        QTY_PRES   = 3'd2,
        QTY_BATT   = 3'd3,
        QTY_FACTOR = 3'd4
    } qty_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic                    lt;
        logic                    eq;
    } alu_res_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] min_value;
        logic [TIME_W-1:0]       min_time;
        logic signed [VAL_W-1:0] max_value;
        logic [TIME_W-1:0]       max_time;
        logic signed [SUM_W-1:0] sum;
        logic [CNT_W-1:0]        count;
    } stat_t;

    localparam stat_t STAT_RESET = '{
        min_value: VAL_MAX,
        min_time:  '0,
        max_value: VAL_MIN,
        max_time:  '0,
        sum:       '0,
        count:     '0
    };

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_M_READ,
        ST_M_LOAD,
        ST_M_LOW,
        ST_M_HIGH,
        ST_M_SUM,
        ST_BATT,
        ST_F_START,
        ST_F_READ,
        ST_F_CMP,
        ST_F_INS,
        ST_CLEAR,
        ST_R_READ,
        ST_R_OUT,
        ST_R_BATT,
        ST_R_FREAD,
        ST_R_FOUT
    } state_t;

    function automatic int addr_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

// ----- rtl/smmst_alu.sv -----
module smmst_alu
    import smmst_pkg::*;
(
    input  alu_op_t                 op,
    input  logic signed [SUM_W-1:0] a,
    input  logic signed [SUM_W-1:0] b,
    output alu_res_t                res
);

    logic [SUM_W:0] a_ext;
    logic [SUM_W:0] b_ext;
    logic [SUM_W:0] raw;
    logic           carry_in;

    always_comb
    begin
        carry_in = (op == ALU_SUB);
        a_ext    = {a[SUM_W-1], a};
        b_ext    = carry_in ? ~{b[SUM_W-1], b} : {b[SUM_W-1], b};
        raw      = a_ext + b_ext + (SUM_W + 1)'(carry_in);
        res.lt   = raw[SUM_W];
        res.eq   = (raw == '0);
        // clamp on overflow of the signed sum
        if (raw[SUM_W] != raw[SUM_W-1])
        begin
            res.sum = raw[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            res.sum = raw[SUM_W-1:0];
        end
    end

endmodule

// ----- rtl/smmst_stat_mem.sv -----
module smmst_stat_mem
    import smmst_pkg::*;
#(
    parameter  int SITES  = SITES_DEF,
    localparam int DEPTH  = SITES * NQ,
    localparam int ADDR_W = addr_w(DEPTH),
    localparam int SITE_W = addr_w(SITES)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [ADDR_W-1:0] rd_addr,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  stat_t             wr_data,
    input  logic              clr_en,
    input  logic [SITE_W-1:0] clr_site,
    output stat_t             rd_data
);

    stat_t            mem [DEPTH];
    stat_t            rd_word_reg;
    logic             rd_valid_reg;
    logic [DEPTH-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_word_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[rd_addr];
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (clr_en)
            begin
                for (int q = 0; q < NQ; q++)
                begin
                    valid_reg[ADDR_W'(int'(clr_site) * NQ + q)] <= 1'b0;
                end
            end
        end
    end

    // an entry never written since reset or clear reads as the reset extremes
    assign rd_data = rd_valid_reg ? rd_word_reg : STAT_RESET;

endmodule

// ----- rtl/smmst_set_mem.sv -----
module smmst_set_mem
    import smmst_pkg::*;
#(
    parameter  int DEPTH  = SITES_DEF * SET_DEPTH_DEF,
    localparam int ADDR_W = addr_w(DEPTH)
)
(
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic [ADDR_W-1:0]      wr_addr,
    input  logic signed [SF_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]      rd_addr,
    output logic signed [SF_W-1:0] rd_data
);

    logic signed [SF_W-1:0] mem [DEPTH];
    logic signed [SF_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/sensor_min_max_sum_tracker_top.sv -----
// Min/max/sum tracker for SITES sensor sites. Takes one item at a time and drops s_axis_tready
// while it works. A record reads, compares and sums each present temperature, humidity or
// pressure reading in turn and skips an absent one, then updates the battery, then scans the
// stored spreading factors of the site's set and inserts a new nonzero one while there is room.
// A report gives 4 + fill items: three measurements, the battery item and one item per set
// entry; a clear resets the site. Items for an unknown site or an unused func code are taken
// and dropped. The block is built around one shared 49-bit adder/comparator doing every min,
// max, sum and set compare in turn, and around the single read port of the statistics and set
// memories. No clearing pass after reset.
module sensor_min_max_sum_tracker_top
    import smmst_pkg::*;
#(
    parameter int SET_DEPTH = SET_DEPTH_DEF,
    parameter int SITES     = SITES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // site, stamp, temperature, humidity, pressure, battery, spread_factor, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // func
    input  logic [FUNC_W-1:0]     s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // low_value, low_time, high_value, high_time, total, sample_count, set_entry
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // quantity
    output logic [QTY_W-1:0]      m_axis_tuser,
    output logic                  m_axis_tlast
);

    localparam int SITE_W = addr_w(SITES);
    localparam int MA_W   = addr_w(SITES * NQ);
    localparam int SA_W   = addr_w(SITES * SET_DEPTH);
    localparam int IDX_W  = addr_w(SET_DEPTH);
    localparam int FILL_W = $clog2(SET_DEPTH + 1);

    logic [SITE_IN_W-1:0]   in_site;
    logic [TIME_W-1:0]      in_stamp;
    logic signed [VAL_W-1:0] in_reading [NQ];
    logic [BAT_W-1:0]       in_bat;
    logic signed [SF_W-1:0] in_sf;
    logic                   in_site_ok;

    state_t                 state_reg, state_next;
    logic [SITE_W-1:0]      site_reg, site_next;
    logic [TIME_W-1:0]      stamp_reg, stamp_next;
    logic signed [VAL_W-1:0] reading_reg [NQ];
    logic                   load_in;
    logic [BAT_W-1:0]       bat_in_reg;
    logic signed [SF_W-1:0] sf_reg;
    logic [1:0]             q_reg, q_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    stat_t                  work_reg, work_next;

    logic [BAT_W-1:0]       bat_first_reg [SITES];
    logic [BAT_W-1:0]       bat_last_reg [SITES];
    logic [SITES-1:0]       bat_seen_reg;
    logic [FILL_W-1:0]      fill_reg [SITES];
    logic                   bat_upd;
    logic                   fill_inc;
    logic                   site_clr;

    logic                   out_valid_reg, out_valid_next;
    qty_t                   out_qty_reg, out_qty_next;
    logic [OUT_DATA_W-1:0]  out_data_reg, out_data_next;
    logic                   out_last_reg, out_last_next;
    logic                   out_free;

    logic [MA_W-1:0]        stat_addr;
    logic                   stat_wr_en;
    stat_t                  stat_wr_data;
    stat_t                  stat_rd_data;
    logic [SA_W-1:0]        set_rd_addr;
    logic [SA_W-1:0]        set_wr_addr;
    logic                   set_wr_en;
    logic signed [SF_W-1:0] set_rd_data;

    alu_op_t                alu_op;
    logic signed [SUM_W-1:0] alu_a, alu_b;
    alu_res_t               alu_res;

    logic [FILL_W-1:0]      cur_fill;
    logic signed [VAL_W-1:0] cur_reading;
    logic signed [SUM_W-1:0] reading_ext;
    logic signed [SUM_W-1:0] sf_ext;
    logic                   idx_at_end;

    assign in_site       = s_axis_tdata[1:0];
    assign in_stamp      = s_axis_tdata[33:2];
    assign in_reading[0] = s_axis_tdata[57:34];
    assign in_reading[1] = s_axis_tdata[81:58];
    assign in_reading[2] = s_axis_tdata[105:82];
    assign in_bat        = s_axis_tdata[121:106];
    assign in_sf         = s_axis_tdata[129:122];
    assign in_site_ok    = (int'(in_site) < SITES);

    assign cur_fill    = fill_reg[site_reg];
    assign cur_reading = reading_reg[q_reg];
    assign reading_ext = SUM_W'(cur_reading);
    assign sf_ext      = SUM_W'(sf_reg);
    assign idx_at_end  = ((FILL_W'(idx_reg) + FILL_W'(1)) == cur_fill);
    assign out_free    = !out_valid_reg || m_axis_tready;

    assign stat_addr   = MA_W'(int'(site_reg) * NQ + int'(q_reg));
    assign set_rd_addr = SA_W'(int'(site_reg) * SET_DEPTH + int'(idx_reg));
    assign set_wr_addr = SA_W'(int'(site_reg) * SET_DEPTH + int'(cur_fill));

    smmst_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    smmst_stat_mem #(
        .SITES (SITES)
    ) u_stat_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (stat_addr),
        .wr_en    (stat_wr_en),
        .wr_addr  (stat_addr),
        .wr_data  (stat_wr_data),
        .clr_en   (site_clr),
        .clr_site (site_reg),
        .rd_data  (stat_rd_data)
    );

    smmst_set_mem #(
        .DEPTH (SITES * SET_DEPTH)
    ) u_set_mem (
        .clk     (clk),
        .wr_en   (set_wr_en),
        .wr_addr (set_wr_addr),
        .wr_data (sf_reg),
        .rd_addr (set_rd_addr),
        .rd_data (set_rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid && in_site_ok)
                begin
                    case (func_t'(s_axis_tuser))
                        FUNC_RECORD: state_next = ST_M_READ;
                        FUNC_REPORT: state_next = ST_R_READ;
                        FUNC_CLEAR:  state_next = ST_CLEAR;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_M_READ:
            begin
                if (cur_reading == '0)
                begin
                    state_next = (q_reg == LAST_Q) ? ST_BATT : ST_M_READ;
                end
                else
                begin
                    state_next = ST_M_LOAD;
                end
            end
            ST_M_LOAD:  state_next = ST_M_LOW;
            ST_M_LOW:   state_next = ST_M_HIGH;
            ST_M_HIGH:  state_next = ST_M_SUM;
            ST_M_SUM:   state_next = (q_reg == LAST_Q) ? ST_BATT : ST_M_READ;
            ST_BATT:    state_next = ST_F_START;
            ST_F_START:
            begin
                if (sf_reg == '0 || int'(cur_fill) >= SET_DEPTH)
                begin
                    state_next = ST_IDLE;
                end
                else if (cur_fill == '0)
                begin
                    state_next = ST_F_INS;
                end
                else
                begin
                    state_next = ST_F_READ;
                end
            end
            ST_F_READ:  state_next = ST_F_CMP;
            ST_F_CMP:
            begin
                if (alu_res.eq)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = idx_at_end ? ST_F_INS : ST_F_READ;
                end
            end
            ST_F_INS:   state_next = ST_IDLE;
            ST_CLEAR:   state_next = ST_IDLE;
            ST_R_READ:  state_next = ST_R_OUT;
            ST_R_OUT:
            begin
                if (out_free)
                begin
                    state_next = (q_reg == LAST_Q) ? ST_R_BATT : ST_R_READ;
                end
            end
            ST_R_BATT:
            begin
                if (out_free)
                begin
                    state_next = (cur_fill == '0) ? ST_IDLE : ST_R_FREAD;
                end
            end
            ST_R_FREAD: state_next = ST_R_FOUT;
            ST_R_FOUT:
            begin
                if (out_free)
                begin
                    state_next = idx_at_end ? ST_IDLE : ST_R_FREAD;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        load_in        = 1'b0;
        site_next      = site_reg;
        stamp_next     = stamp_reg;
        q_next         = q_reg;
        idx_next       = idx_reg;
        work_next      = work_reg;
        bat_upd        = 1'b0;
        fill_inc       = 1'b0;
        site_clr       = 1'b0;
        stat_wr_en     = 1'b0;
        stat_wr_data   = work_reg;
        set_wr_en      = 1'b0;
        alu_op         = ALU_SUB;
        alu_a          = reading_ext;
        alu_b          = SUM_W'(work_reg.min_value);
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_qty_next   = out_qty_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    load_in    = 1'b1;
                    site_next  = SITE_W'(in_site);
                    stamp_next = in_stamp;
                    q_next     = '0;
                    idx_next   = '0;
                end
            end
            ST_M_READ:
            begin
                if (cur_reading == '0 && q_reg != LAST_Q)
                begin
                    q_next = q_reg + 2'd1;
                end
            end
            ST_M_LOAD:
            begin
                work_next = stat_rd_data;
            end
            ST_M_LOW:
            begin
                if (work_reg.count == '0 || alu_res.lt)
                begin
                    work_next.min_value = cur_reading;
                    work_next.min_time  = stamp_reg;
                end
            end
            ST_M_HIGH:
            begin
                alu_a = SUM_W'(work_reg.max_value);
                alu_b = reading_ext;
                if (work_reg.count == '0 || alu_res.lt)
                begin
                    work_next.max_value = cur_reading;
                    work_next.max_time  = stamp_reg;
                end
            end
            ST_M_SUM:
            begin
                alu_op             = ALU_ADD;
                alu_a              = work_reg.sum;
                alu_b              = reading_ext;
                stat_wr_en         = 1'b1;
                stat_wr_data.sum   = alu_res.sum;
                stat_wr_data.count = (work_reg.count == CNT_MAX) ? work_reg.count
                                                                 : work_reg.count + CNT_W'(1);
                if (q_reg != LAST_Q)
                begin
                    q_next = q_reg + 2'd1;
                end
            end
            ST_BATT:
            begin
                bat_upd = (bat_in_reg != '0);
            end
            ST_F_START:
            begin
                idx_next = '0;
            end
            ST_F_CMP:
            begin
                alu_a    = sf_ext;
                alu_b    = SUM_W'(set_rd_data);
                idx_next = idx_reg + IDX_W'(1);
            end
            ST_F_INS:
            begin
                set_wr_en = 1'b1;
                fill_inc  = 1'b1;
            end
            ST_CLEAR:
            begin
                site_clr = 1'b1;
            end
            ST_R_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_qty_next   = qty_t'({1'b0, q_reg});
                    out_last_next  = 1'b0;
                    out_data_next  = {SF_W'(0), stat_rd_data.count, stat_rd_data.sum,
                                      stat_rd_data.max_time, stat_rd_data.max_value,
                                      stat_rd_data.min_time, stat_rd_data.min_value};
                    q_next         = q_reg + 2'd1;
                end
            end
            ST_R_BATT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_qty_next   = QTY_BATT;
                    out_last_next  = (cur_fill == '0);
                    out_data_next  = {SF_W'(0), CNT_W'(cur_fill), SUM_W'(0), TIME_W'(0),
                                      VAL_W'(bat_last_reg[site_reg]), TIME_W'(0),
                                      VAL_W'(bat_first_reg[site_reg])};
                    idx_next       = '0;
                end
            end
            ST_R_FOUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_qty_next   = QTY_FACTOR;
                    out_last_next  = idx_at_end;
                    out_data_next  = {set_rd_data, (OUT_DATA_W - SF_W)'(0)};
                    idx_next       = idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                load_in = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            bat_seen_reg  <= '0;
            for (int s = 0; s < SITES; s++)
            begin
                bat_first_reg[s] <= '0;
                bat_last_reg[s]  <= '0;
                fill_reg[s]      <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (bat_upd)
            begin
                if (!bat_seen_reg[site_reg])
                begin
                    bat_first_reg[site_reg] <= bat_in_reg;
                    bat_seen_reg[site_reg]  <= 1'b1;
                end
                bat_last_reg[site_reg] <= bat_in_reg;
            end
            if (fill_inc)
            begin
                fill_reg[site_reg] <= cur_fill + FILL_W'(1);
            end
            if (site_clr)
            begin
                bat_first_reg[site_reg] <= '0;
                bat_last_reg[site_reg]  <= '0;
                bat_seen_reg[site_reg]  <= 1'b0;
                fill_reg[site_reg]      <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        site_reg     <= site_next;
        stamp_reg    <= stamp_next;
        q_reg        <= q_next;
        idx_reg      <= idx_next;
        work_reg     <= work_next;
        out_qty_reg  <= out_qty_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        if (load_in)
        begin
            reading_reg <= in_reading;
            bat_in_reg  <= in_bat;
            sf_reg      <= in_sf;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_qty_reg;
    assign m_axis_tlast  = out_last_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(cur_fill) <= SET_DEPTH)
        else $error("set fill beyond depth");

    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |->
            (m_axis_tuser == QTY_BATT || m_axis_tuser == QTY_FACTOR))
        else $error("run ends on a measurement item");

    a_entry_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == QTY_FACTOR |->
            m_axis_tdata[OUT_DATA_W-1 -: SF_W] != '0)
        else $error("zero spreading factor reported");

    a_insert_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        set_wr_en |=> int'(cur_fill) <= SET_DEPTH && $past(int'(cur_fill)) < SET_DEPTH)
        else $error("insert into a full set");

endmodule

// ----- tb/site_stats_monitor.sv -----
`timescale 1ns / 100ps

module site_stats_monitor
    import smmst_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [IN_DATA_W-1:0]  in_data,
    input  logic [FUNC_W-1:0]     in_func,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [OUT_DATA_W-1:0] out_data,
    input  logic [QTY_W-1:0]      out_qty,
    input  logic                  out_last,
    output int                    mismatches,
    output int                    waiting,
    output int                    matched
);

    localparam int SITES     = SITES_DEF;
    localparam int SET_DEPTH = SET_DEPTH_DEF;

    typedef struct {
        logic [QTY_W-1:0] qty;
        logic [VAL_W-1:0] lo;
        logic [TIME_W-1:0] lt;
        logic [VAL_W-1:0] hi;
        logic [TIME_W-1:0] ht;
        logic [SUM_W-1:0] tot;
        logic [CNT_W-1:0] cnt;
        logic [SF_W-1:0]  entry;
        logic             last;
    } report_item_t;

    logic signed [VAL_W-1:0] lo_val [SITES*NQ];
    logic [TIME_W-1:0]       lo_stamp [SITES*NQ];
    logic signed [VAL_W-1:0] hi_val [SITES*NQ];
    logic [TIME_W-1:0]       hi_stamp [SITES*NQ];
    logic signed [SUM_W-1:0] run_sum [SITES*NQ];
    logic [CNT_W-1:0]        run_cnt [SITES*NQ];
    logic [BAT_W-1:0]        batt_first [SITES];
    logic [BAT_W-1:0]        batt_latest [SITES];
    logic                    batt_seen [SITES];
    logic signed [SF_W-1:0]  factor_list [SITES][SET_DEPTH];
    int                      factor_fill [SITES];

    report_item_t pending_reports[$];

    task automatic wipe_site(input int s);
        int k;
        for (k = s * NQ; k < s * NQ + NQ; k++)
        begin
            lo_val[k]   = VAL_MAX;
            hi_val[k]   = VAL_MIN;
            lo_stamp[k] = '0;
            hi_stamp[k] = '0;
            run_sum[k]  = '0;
            run_cnt[k]  = '0;
        end
        batt_first[s]  = '0;
        batt_latest[s] = '0;
        batt_seen[s]   = 1'b0;
        factor_fill[s] = 0;
        for (k = 0; k < SET_DEPTH; k++)
            factor_list[s][k] = '0;
    endtask

    task automatic fold_reading(input int k, input logic signed [VAL_W-1:0] r,
                                input logic [TIME_W-1:0] t);
        logic signed [SUM_W:0] acc;
        if (r == 0)
            return;
        if (run_cnt[k] == 0 || r < lo_val[k])
        begin
            lo_val[k]   = r;
            lo_stamp[k] = t;
        end
        if (run_cnt[k] == 0 || r > hi_val[k])
        begin
            hi_val[k]   = r;
            hi_stamp[k] = t;
        end
        acc = (SUM_W + 1)'(run_sum[k]) + (SUM_W + 1)'(r);
        if (acc > (SUM_W + 1)'(SUM_MAX))
            acc = (SUM_W + 1)'(SUM_MAX);
        if (acc < (SUM_W + 1)'(SUM_MIN))
            acc = (SUM_W + 1)'(SUM_MIN);
        run_sum[k] = acc[SUM_W-1:0];
        if (run_cnt[k] != CNT_MAX)
            run_cnt[k] = run_cnt[k] + CNT_W'(1);
    endtask

    function automatic report_item_t make_item(input qty_t q, input logic [VAL_W-1:0] lo,
                                               input logic [TIME_W-1:0] lt,
                                               input logic [VAL_W-1:0] hi,
                                               input logic [TIME_W-1:0] ht,
                                               input logic [SUM_W-1:0] tot,
                                               input logic [CNT_W-1:0] cnt,
                                               input logic [SF_W-1:0] entry,
                                               input logic last);
        report_item_t it;
        it.qty   = q;
        it.lo    = lo;
        it.lt    = lt;
        it.hi    = hi;
        it.ht    = ht;
        it.tot   = tot;
        it.cnt   = cnt;
        it.entry = entry;
        it.last  = last;
        return it;
    endfunction

    task automatic absorb_item(input logic [FUNC_W-1:0] fn, input logic [IN_DATA_W-1:0] d);
        int                      s;
        int                      q;
        int                      k;
        int                      n;
        logic                    found;
        logic [TIME_W-1:0]       stamp;
        logic signed [VAL_W-1:0] reading [NQ];
        logic [BAT_W-1:0]        batt;
        logic signed [SF_W-1:0]  sf;
        s          = int'(d[1:0]);
        stamp      = d[33:2];
        reading[0] = d[57:34];
        reading[1] = d[81:58];
        reading[2] = d[105:82];
        batt       = d[121:106];
        sf         = d[129:122];
        if (s >= SITES)
            return;
        case (fn)
            FUNC_RECORD:
            begin
                for (q = 0; q < NQ; q++)
                    fold_reading(s * NQ + q, reading[q], stamp);
                if (batt != 0)
                begin
                    if (!batt_seen[s])
                    begin
                        batt_first[s] = batt;
                        batt_seen[s]  = 1'b1;
                    end
                    batt_latest[s] = batt;
                end
                found = 1'b0;
                for (k = 0; k < factor_fill[s]; k++)
                    if (factor_list[s][k] == sf)
                        found = 1'b1;
                if (!found && sf != 0 && factor_fill[s] < SET_DEPTH)
                begin
                    factor_list[s][factor_fill[s]] = sf;
                    factor_fill[s]++;
                end
            end
            FUNC_REPORT:
            begin
                n = 4 + factor_fill[s];
                for (q = 0; q < NQ; q++)
                begin
                    k = s * NQ + q;
                    pending_reports.push_back(make_item(qty_t'(q), lo_val[k], lo_stamp[k],
                        hi_val[k], hi_stamp[k], run_sum[k], run_cnt[k], '0, 1'b0));
                end
                pending_reports.push_back(make_item(QTY_BATT, {8'h00, batt_first[s]}, '0,
                    {8'h00, batt_latest[s]}, '0, '0, CNT_W'(factor_fill[s]), '0, n == 4));
                for (k = 0; k < factor_fill[s]; k++)
                    pending_reports.push_back(make_item(QTY_FACTOR, '0, '0, '0, '0, '0, '0,
                        factor_list[s][k], k == factor_fill[s] - 1));
            end
            FUNC_CLEAR:
                wipe_site(s);
            default:
            begin
            end
        endcase
    endtask

    task automatic check_field(input string label, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        report_item_t want;
        if (!rst_n)
        begin
            for (int s = 0; s < SITES; s++)
                wipe_site(s);
            pending_reports.delete();
            mismatches = 0;
            matched    = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_reports.size() == 0)
                begin
                    $display("%0t: unexpected item, expected none, got quantity %0d data %0h",
                             $time, out_qty, out_data);
                    mismatches++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    check_field("quantity", want.qty, out_qty);
                    check_field("low_value", want.lo, out_data[23:0]);
                    check_field("low_time", want.lt, out_data[55:24]);
                    check_field("high_value", want.hi, out_data[79:56]);
                    check_field("high_time", want.ht, out_data[111:80]);
                    check_field("total", want.tot, out_data[159:112]);
                    check_field("sample_count", want.cnt, out_data[183:160]);
                    check_field("set_entry", want.entry, out_data[191:184]);
                    check_field("last", want.last, out_last);
                    matched++;
                end
            end
            if (in_valid && in_ready)
                absorb_item(in_func, in_data);
        end
        waiting = pending_reports.size();
    end

endmodule

// ----- tb/sensor_min_max_sum_tracker_top_test.sv -----
`timescale 1ns / 100ps

module sensor_min_max_sum_tracker_top_test
    import smmst_pkg::*;
();

    localparam logic [FUNC_W-1:0] FUNC_SPARE   = 2'd3;
    localparam logic [1:0]        SITE_A       = 2'd0;
    localparam logic [1:0]        SITE_B       = 2'd1;
    localparam logic [1:0]        SITE_UNKNOWN = 2'd2;
    localparam logic [1:0]        SITE_SPARE   = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [FUNC_W-1:0]     s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [QTY_W-1:0]      m_axis_tuser;
    logic                  m_axis_tlast;

    int mismatches;
    int waiting;
    int matched;
    int n_record;
    int n_report;
    int n_clear;
    int n_ignored;
    bit send_calm;
    bit take_calm;

    always #5 clk = ~clk;

    sensor_min_max_sum_tracker_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    site_stats_monitor u_monitor (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (s_axis_tdata),
        .in_func    (s_axis_tuser),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .out_qty    (m_axis_tuser),
        .out_last   (m_axis_tlast),
        .mismatches (mismatches),
        .waiting    (waiting),
        .matched    (matched)
    );

    task automatic send(input logic [FUNC_W-1:0] fn, input logic [IN_DATA_W-1:0] d);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, 17);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= fn;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (d[1:0] >= SITES_DEF || fn == FUNC_SPARE)
            n_ignored++;
        else if (fn == FUNC_RECORD)
            n_record++;
        else if (fn == FUNC_REPORT)
            n_report++;
        else
            n_clear++;
        if ($urandom_range(0, 24) == 0)
            send_calm = !send_calm;
    endtask

    task automatic put_record(input logic [1:0] site, input logic [TIME_W-1:0] stamp,
                              input logic [VAL_W-1:0] t, input logic [VAL_W-1:0] h,
                              input logic [VAL_W-1:0] p, input logic [BAT_W-1:0] b,
                              input logic [SF_W-1:0] sf);
        send(FUNC_RECORD, {6'b0, sf, b, p, h, t, stamp, site});
    endtask

    task automatic put_cmd(input logic [FUNC_W-1:0] fn, input logic [1:0] site);
        send(fn, {{(IN_DATA_W-2){1'b0}}, site});
    endtask

    function automatic logic [VAL_W-1:0] pick_reading();
        case ($urandom_range(0, 9))
            0, 1:    return '0;
            2:       return VAL_MAX;
            3:       return VAL_MIN;
            4, 5:    return VAL_W'($urandom_range(0, 200) - 100);
            default: return VAL_W'($urandom());
        endcase
    endfunction

    function automatic logic [BAT_W-1:0] pick_battery();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return BAT_W'($urandom_range(1, 10));
            default: return BAT_W'($urandom());
        endcase
    endfunction

    function automatic logic [SF_W-1:0] pick_factor();
        case ($urandom_range(0, 4))
            0:       return '0;
            1, 2:    return SF_W'($urandom_range(0, 10) - 5);
            default: return SF_W'($urandom());
        endcase
    endfunction

    function automatic logic [FUNC_W-1:0] FUNC_FIELD_RAND();
        return FUNC_W'($urandom_range(0, 3));
    endfunction

    initial
    begin
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            int stall;
            stall = take_calm ? 0 : $urandom_range(0, 17);
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            if ($urandom_range(0, 24) == 0)
                take_calm = !take_calm;
        end
    end

    initial
    begin
        #10_000_000;
        $display("sensor_min_max_sum_tracker_top_test NOT OK");
        $finish;
    end

    initial
    begin
        int                 pick;
        logic [1:0]         site;
        logic [TIME_W-1:0]  clock_stamp;
        logic [IN_DATA_W-1:0] junk;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FUNC_RECORD;
        rst_n         = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty site, extremes, ties, absent readings, ignored items
        put_cmd(FUNC_REPORT, SITE_A);
        put_record(SITE_A, 32'hFFFF_FFFF, VAL_MAX, VAL_MIN, 24'sd1, 16'hFFFF, 8'sh80);
        put_record(SITE_A, 32'd5, VAL_MAX, VAL_MIN, -24'sd1, 16'd1, 8'sh7F);
        put_record(SITE_A, 32'd7, '0, '0, '0, '0, '0);
        put_record(SITE_A, 32'd9, VAL_MIN, VAL_MAX, -24'sd1, '0, 8'sh80);
        put_record(SITE_UNKNOWN, 32'd11, 24'sd3, 24'sd3, 24'sd3, 16'd3, 8'sd3);
        put_record(SITE_SPARE, 32'd12, 24'sd4, 24'sd4, 24'sd4, 16'd4, 8'sd4);
        put_cmd(FUNC_REPORT, SITE_UNKNOWN);
        put_cmd(FUNC_CLEAR, SITE_SPARE);
        put_cmd(FUNC_SPARE, SITE_A);
        put_cmd(FUNC_REPORT, SITE_A);
        put_cmd(FUNC_REPORT, SITE_B);
        put_record(SITE_B, 32'd20, -24'sd50, 24'sd60, 24'sd70, 16'd200, 8'sd7);
        put_record(SITE_B, 32'd21, 24'sd40, 24'sd60, 24'sd10, 16'd0, -8'sd7);
        put_cmd(FUNC_REPORT, SITE_B);
        put_cmd(FUNC_CLEAR, SITE_A);
        put_cmd(FUNC_REPORT, SITE_A);

        clock_stamp = 32'd100;
        while (n_record + n_report + n_clear < 200)
        begin
            pick = $urandom_range(0, 99);
            site = 2'($urandom_range(0, 1));
            if (pick < 6)
            begin
                junk = IN_DATA_W'({$urandom(), $urandom(), $urandom(), $urandom(),
                                   $urandom()});
                if (pick < 3)
                    junk[1:0] = 2'($urandom_range(2, 3));
                else
                    junk[1:0] = site;
                send(pick < 3 ? FUNC_FIELD_RAND() : FUNC_SPARE, junk);
            end
            else if (pick < 9)
            begin
                put_cmd(FUNC_CLEAR, site);
            end
            else if (pick < 24)
            begin
                put_cmd(FUNC_REPORT, site);
            end
            else
            begin
                clock_stamp = clock_stamp + $urandom_range(0, 3);
                put_record(site, $urandom_range(0, 1) ? clock_stamp : $urandom(),
                           pick_reading(), pick_reading(), pick_reading(),
                           pick_battery(), pick_factor());
            end
        end
        s_axis_tvalid <= 1'b0;

        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        $display("covered %0d records, %0d reports, %0d clears, %0d ignored items",
                 n_record, n_report, n_clear, n_ignored);
        $display("checked %0d result items against the predicted site statistics", matched);
        if (mismatches == 0)
            $display("sensor_min_max_sum_tracker_top_test OK");
        else
            $display("sensor_min_max_sum_tracker_top_test NOT OK");
        $finish;
    end

endmodule
